FILE: hw/rtl/canonical_kmer_hasher_core_assert.svh
// Assertion macros for the canonical k-mer hasher
`ifndef CANONICAL_KMER_HASHER_CORE_ASSERT_SVH
`define CANONICAL_KMER_HASHER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define CKH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CKH_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) pre |=> post) else $error(msg);
`else
`define CKH_ASSERT(lbl, prop, msg)
`define CKH_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

FILE: hw/rtl/ckh_pkg.sv
// Shared types, constants and helper functions for the canonical k-mer hasher
`timescale 1ns / 1ps
package ckh_pkg;

	localparam int KMER_W     = 62;
	localparam int CHAR_W     = 8;
	localparam int LEN_W      = 5;
	localparam int BUCKET_W   = 24;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	localparam logic [LEN_W-1:0] KLEN_RESET  = 5'd31;
	localparam logic [LEN_W-1:0] PBITS_RESET = 5'd14;
	localparam logic [LEN_W-1:0] PBITS_MAX   = 5'd24;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KMER_LENGTH = 1'b0,
		CFG_PREFIX_BITS = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic       ok;
		logic [1:0] code;
	} base_t;

	typedef struct packed {
		logic [KMER_W-1:0]   canon;
		logic [KMER_W-1:0]   mask;
		logic [BUCKET_W-1:0] pmask;
	} kmer_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	function automatic base_t map_base(input logic [CHAR_W-1:0] ch);
		base_t b;
		b.ok = 1'b1;
		case (ch)
			8'h00, "A", "a": b.code = 2'd0;
			8'h01, "C", "c": b.code = 2'd1;
			8'h02, "G", "g": b.code = 2'd2;
			8'h03, "T", "t", "U", "u": b.code = 2'd3;
			default: begin
				b.ok = 1'b0;
				b.code = 2'd0;
			end
		endcase
		return b;
	endfunction

	function automatic logic [LEN_W-1:0] eff_klen(input logic [LEN_W-1:0] k);
		return (k == '0) ? LEN_W'(1) : k;
	endfunction

	function automatic logic [LEN_W-1:0] eff_pbits(input logic [LEN_W-1:0] p);
		return (p > PBITS_MAX) ? PBITS_MAX : p;
	endfunction

	// k is at least one, so the shift stays within the word
	function automatic logic [KMER_W-1:0] kmer_mask(input logic [LEN_W-1:0] k);
		logic [6:0] sh;
		sh = 7'(KMER_W) - 7'({k, 1'b0});
		return {KMER_W{1'b1}} >> sh;
	endfunction

	function automatic logic [BUCKET_W-1:0] bucket_mask(input logic [LEN_W-1:0] p);
		logic [LEN_W-1:0] sh;
		sh = LEN_W'(BUCKET_W) - p;
		return {BUCKET_W{1'b1}} >> sh;
	endfunction

endpackage

FILE: hw/rtl/ckh_in_if.sv
// Character channel: one sequence byte and its start flag per word
`timescale 1ns / 1ps
interface ckh_in_if import ckh_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] base_char;
	logic              seq_start;

	modport source(output valid, base_char, seq_start, input ready);
	modport sink(input valid, base_char, seq_start, output ready);
endinterface

FILE: hw/rtl/ckh_out_if.sv
// Hash channel: one hashed canonical k-mer and its bucket index per word
`timescale 1ns / 1ps
interface ckh_out_if import ckh_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [KMER_W-1:0]   kmer_hash;
	logic [BUCKET_W-1:0] bucket_index;

	modport source(output valid, kmer_hash, bucket_index, input ready);
	modport sink(input valid, kmer_hash, bucket_index, output ready);
endinterface

FILE: hw/rtl/ckh_front.sv
// Front end: base decode, forward and reverse-complement k-mer tracking, canonical pick
`timescale 1ns / 1ps
module ckh_front import ckh_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	ckh_in_if.sink           chars,
	input  logic [LEN_W-1:0] klen,
	input  logic [LEN_W-1:0] pbits,
	input  fifo_stat_t       stat,
	output logic             push,
	output kmer_job_t        job
);

	logic [KMER_W-1:0] fwd_q, rev_q, fwd_base, rev_base, fwd_n, rev_n, mask;
	logic [LEN_W-1:0]  cnt_q, cnt_base, cnt_inc, cnt_n;
	logic [5:0]        rev_sh;
	logic              acc;
	base_t             b;

	assign chars.ready = !stat.full;
	assign acc = chars.valid && chars.ready;
	assign b = map_base(chars.base_char);
	assign mask = kmer_mask(klen);
	assign rev_sh = {klen - LEN_W'(1), 1'b0};

	always_comb begin
		fwd_base = chars.seq_start ? '0 : fwd_q;
		rev_base = chars.seq_start ? '0 : rev_q;
		cnt_base = chars.seq_start ? '0 : cnt_q;
		fwd_n = ((fwd_base << 2) | KMER_W'(b.code)) & mask;
		rev_n = ((rev_base >> 2) | (KMER_W'(2'd3 - b.code) << rev_sh)) & mask;
		cnt_inc = (cnt_base < klen) ? cnt_base + LEN_W'(1) : cnt_base;
		cnt_n = (cnt_inc > klen) ? klen : cnt_inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= '0;
			rev_q <= '0;
			cnt_q <= '0;
		end else if (acc) begin
			if (b.ok) begin
				fwd_q <= fwd_n;
				rev_q <= rev_n;
				cnt_q <= cnt_n;
			end else begin
				fwd_q <= '0;
				rev_q <= '0;
				cnt_q <= '0;
			end
		end
	end

	assign push = acc && b.ok && (cnt_n == klen);

	always_comb begin
		job.canon = (fwd_n < rev_n) ? fwd_n : rev_n;
		job.mask = mask;
		job.pmask = bucket_mask(pbits);
	end

endmodule

FILE: hw/rtl/ckh_fifo.sv
// Four-word queue between the front end and the hash pipeline
`timescale 1ns / 1ps
module ckh_fifo import ckh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  kmer_job_t  wr_job,
	input  logic       pop,
	output kmer_job_t  rd_job,
	output fifo_stat_t stat
);

	kmer_job_t             slot_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;

	assign stat.full = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rd_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + FIFO_CNT_W'(1);
				2'b01: cnt_q <= cnt_q - FIFO_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: hw/rtl/ckh_hash.sv
// Back end: four-stage masked invertible hash with output register
`timescale 1ns / 1ps
module ckh_hash import ckh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  kmer_job_t  job,
	input  fifo_stat_t stat,
	output logic       pop,
	ckh_out_if.source  hashes
);

	logic                v_s1, v_s2, v_s3, v_s4;
	logic                en1, en2, en3, en4;
	logic [KMER_W-1:0]   key_s1, key_s2, key_s3, key_s4;
	logic [KMER_W-1:0]   mask_s1, mask_s2, mask_s3;
	logic [BUCKET_W-1:0] pmask_s1, pmask_s2, pmask_s3, bucket_s4;
	logic [KMER_W-1:0]   t1, t2, t3, h1, h2, h3, h4;

	assign en4 = !v_s4 || hashes.ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign pop = en1 && !stat.empty;

	always_comb begin
		t1 = (~job.canon + (job.canon << 21)) & job.mask;
		h1 = t1 ^ (t1 >> 24);
		t2 = (key_s1 + (key_s1 << 3) + (key_s1 << 8)) & mask_s1;
		h2 = t2 ^ (t2 >> 14);
		t3 = (key_s2 + (key_s2 << 2) + (key_s2 << 4)) & mask_s2;
		h3 = t3 ^ (t3 >> 28);
		h4 = (key_s3 + (key_s3 << 31)) & mask_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= !stat.empty;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			key_s1 <= h1;
			mask_s1 <= job.mask;
			pmask_s1 <= job.pmask;
		end
		if (en2) begin
			key_s2 <= h2;
			mask_s2 <= mask_s1;
			pmask_s2 <= pmask_s1;
		end
		if (en3) begin
			key_s3 <= h3;
			mask_s3 <= mask_s2;
			pmask_s3 <= pmask_s2;
		end
		if (en4) begin
			key_s4 <= h4;
			bucket_s4 <= h4[BUCKET_W-1:0] & pmask_s3;
		end
	end

	assign hashes.valid = v_s4;
	assign hashes.kmer_hash = key_s4;
	assign hashes.bucket_index = bucket_s4;

endmodule

FILE: hw/rtl/canonical_kmer_hasher_core.sv
// Top level of the canonical k-mer hasher: config registers, front end, queue, hash pipeline
//
//  channel  dir  fields                              handshake
//  chars    in   base_char[7:0], seq_start           valid/ready
//  hashes   out  kmer_hash[61:0], bucket_index[23:0] valid/ready
//  cfg      in   cfg_index[0], cfg_data[4:0]         cfg_we, no back-pressure
//
// One character word per cycle sustained; the k-mer state update sets that rate.
// An accepted character's hash passes the queue and stages s1 to s4 before hashes.
// chars stalls only when the four-word queue is full; hashes back-pressure
// fills the hash pipeline and then the queue.
// Reset clears the k-mer state, sets k = 31 and prefix bits = 14.
`timescale 1ns / 1ps
`include "canonical_kmer_hasher_core_assert.svh"
module canonical_kmer_hasher_core import ckh_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	ckh_in_if.sink                chars,
	ckh_out_if.source             hashes,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [LEN_W-1:0]    klen_q, pbits_q, klen_eff, pbits_eff;
	logic                push, pop;
	kmer_job_t           wr_job, rd_job;
	fifo_stat_t          stat;
	logic [KMER_W-1:0]   hash_spill;
	logic [BUCKET_W-1:0] bucket_spill;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q <= KLEN_RESET;
			pbits_q <= PBITS_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_KMER_LENGTH: klen_q <= cfg_data;
				CFG_PREFIX_BITS: pbits_q <= cfg_data;
				default: klen_q <= klen_q;
			endcase
		end
	end

	assign klen_eff = eff_klen(klen_q);
	assign pbits_eff = eff_pbits(pbits_q);

	ckh_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.klen   (klen_eff),
		.pbits  (pbits_eff),
		.stat   (stat),
		.push   (push),
		.job    (wr_job)
	);

	ckh_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.rd_job (rd_job),
		.stat   (stat)
	);

	ckh_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.job    (rd_job),
		.stat   (stat),
		.pop    (pop),
		.hashes (hashes)
	);

	assign hash_spill = hashes.kmer_hash & ~kmer_mask(klen_eff);
	assign bucket_spill = hashes.bucket_index & ~hashes.kmer_hash[BUCKET_W-1:0];

	`CKH_ASSERT(a_no_overflow, !(push && stat.full), "push into full queue")
	`CKH_ASSERT_NEXT(a_push_lands, push && !pop, !stat.empty, "pushed word lost")
	`CKH_ASSERT(a_hash_in_mask, hashes.valid |-> (hash_spill == '0), "hash exceeds 2k bits")
	`CKH_ASSERT(a_bucket_sub, hashes.valid |-> (bucket_spill == '0), "bucket not from hash")

endmodule
